>>> hw/rtl/stnf_pkg.sv
// Package for the second/third neighbor finder: graph sizes, field widths,
// memory geometry, beat codes. Used by second_third_neighbor_finder.
// No dependencies.
`timescale 1ns / 1ps

package stnf_pkg;

    // Graph geometry
    localparam int DEGREE     = 3;
    localparam int NODES      = 1024;
    localparam int ID_W       = 10;
    localparam int SLOT_W     = 2;
    localparam int ROW_IW     = (DEGREE > 1) ? $clog2(DEGREE) : 1;
    localparam int ADJ_DEPTH  = NODES * DEGREE;
    localparam int ADJ_AW     = $clog2(ADJ_DEPTH);

    // Result list: second neighbors first, then third neighbors
    localparam int LIST_DEPTH = 48;
    localparam int LIST_AW    = $clog2(LIST_DEPTH + 1);
    localparam int SEC_CAP    = 15;
    localparam int SC_W       = 4;
    localparam int TC_W       = 6;

    // Stream beat layout
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // Input actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_SECOND = 2'd0;
    localparam logic [1:0] KIND_THIRD  = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;

endpackage

>>> hw/rtl/stnf_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// Holds the adjacency table and the result list of the neighbor finder.
// No dependencies.
`timescale 1ns / 1ps

module stnf_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 48,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/second_third_neighbor_finder.sv
// Top level of the second/third neighbor finder: stream ports, sequencer,
// adjacency RAM and result list RAM. Depends on stnf_pkg and stnf_ram.
`timescale 1ns / 1ps

// A write beat (tuser 0) stores one neighbor id into one adjacency slot;
// writes with slot >= DEGREE or node >= NODES are dropped.
// A query beat (tuser 1) walks the graph from the named node with a single
// sequencer around one adjacency read port and one list read port. It first
// fetches the node's row one slot at a time; then, per source node and per
// slot, it reads the candidate and compares it against the list entries one
// by one, and a last step past the final entry appends a new candidate when
// the list has room. The sources are the DEGREE direct neighbors, then each
// second neighbor found; a separate step switches between the two kinds of
// source and another ends the walk. Each result beat is then read from the
// list, registered, and held until the master side takes it. The input is
// not ready until the last result beat of a query has been taken.
// All adjacency slots that a query can reach must be written first; there is
// no clearing pass.
module second_third_neighbor_finder
    import stnf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // node[9:0], slot[11:10], neighbor[21:12]
    input  logic                   i_s_axis_tuser,  // action[0]
    // master side
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // found_node[9:0], second_count[13:10],
                                                    // third_count[19:14]
    output logic [1:0]             o_m_axis_tuser,  // kind[1:0]
    output logic                   o_m_axis_tlast
);

    // sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_ROW_RD   = 4'd1;
    localparam logic [3:0] ST_ROW_WT   = 4'd2;
    localparam logic [3:0] ST_SRC      = 4'd3;
    localparam logic [3:0] ST_SRC_WT   = 4'd4;
    localparam logic [3:0] ST_NB_RD    = 4'd5;
    localparam logic [3:0] ST_NB_WT    = 4'd6;
    localparam logic [3:0] ST_SCAN     = 4'd7;
    localparam logic [3:0] ST_SCAN_WT  = 4'd8;
    localparam logic [3:0] ST_NEXT     = 4'd9;
    localparam logic [3:0] ST_OUT_RD   = 4'd10;
    localparam logic [3:0] ST_OUT_WT   = 4'd11;
    localparam logic [3:0] ST_OUT_HOLD = 4'd12;

    // input beat fields
    logic              in_action;
    logic [ID_W-1:0]   in_node;
    logic [SLOT_W-1:0] in_slot;
    logic [ID_W-1:0]   in_nb;
    logic              in_fire;
    logic              out_fire;

    assign in_action = i_s_axis_tuser;
    assign in_node   = i_s_axis_tdata[ID_W-1:0];
    assign in_slot   = i_s_axis_tdata[ID_W+SLOT_W-1:ID_W];
    assign in_nb     = i_s_axis_tdata[2*ID_W+SLOT_W-1:ID_W+SLOT_W];

    // registers
    logic [3:0]         r_state, n_state;
    logic [ID_W-1:0]    r_node, n_node;
    logic [ID_W-1:0]    r_row [DEGREE];
    logic [ID_W-1:0]    n_row [DEGREE];
    logic [SLOT_W-1:0]  r_s, n_s;
    logic [SC_W-1:0]    r_s1, n_s1;
    logic               r_third, n_third;
    logic [ID_W-1:0]    r_v, n_v;
    logic [ID_W-1:0]    r_cand, n_cand;
    logic [LIST_AW-1:0] r_k, n_k;
    logic [SC_W-1:0]    r_sc, n_sc;
    logic [TC_W-1:0]    r_tc, n_tc;
    logic               r_ovalid, n_ovalid;
    logic [1:0]         r_okind, n_okind;
    logic [ID_W-1:0]    r_onode, n_onode;
    logic [SC_W-1:0]    r_osc, n_osc;
    logic [TC_W-1:0]    r_otc, n_otc;
    logic               r_olast, n_olast;

    // memory ports
    logic               adj_we;
    logic [ADJ_AW-1:0]  adj_waddr;
    logic [ADJ_AW-1:0]  adj_raddr;
    logic [ID_W-1:0]    adj_q;
    logic [ID_W-1:0]    rd_id;
    logic               list_we;
    logic [LIST_AW-1:0] list_waddr;
    logic [LIST_AW-1:0] list_raddr;
    logic [ID_W-1:0]    list_q;

    // derived values
    logic               node_ok;
    logic               v_ok;
    logic               wr_ok;
    logic [ID_W-1:0]    cand;
    logic               row_hit;
    logic [LIST_AW-1:0] total;
    logic [LIST_AW-1:0] scan_lim;
    logic               can_insert;
    logic [LIST_AW-1:0] k_inc;

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire = r_ovalid && i_m_axis_tready;

    assign node_ok = ({1'b0, r_node} < (ID_W+1)'(NODES));
    assign v_ok    = ({1'b0, r_v} < (ID_W+1)'(NODES));
    assign wr_ok   = ({1'b0, in_node} < (ID_W+1)'(NODES))
                   && ({1'b0, in_slot} < (SLOT_W+1)'(DEGREE));

    assign total    = LIST_AW'(r_sc) + LIST_AW'(r_tc);
    assign scan_lim = r_third ? total : LIST_AW'(r_sc);
    assign can_insert = r_third ? (total < LIST_AW'(LIST_DEPTH))
                                : (r_sc < SC_W'(SEC_CAP));
    assign k_inc    = r_k + LIST_AW'(1);

    // adjacency addressing: id * DEGREE + slot
    assign adj_we    = in_fire && (in_action == ACT_WRITE) && wr_ok;
    assign adj_waddr = ADJ_AW'(ADJ_AW'(in_node) * ADJ_AW'(DEGREE) + ADJ_AW'(in_slot));
    assign rd_id     = (r_state == ST_ROW_RD) ? r_node : r_v;
    assign adj_raddr = ADJ_AW'(ADJ_AW'(rd_id) * ADJ_AW'(DEGREE) + ADJ_AW'(r_s));

    // list addressing: the source index or the scan/output index
    assign list_waddr = total;
    assign list_raddr = (r_state == ST_SRC) ? LIST_AW'(r_s1) : r_k;

    // candidate from the neighbor read; ids out of range have an all-zero row
    assign cand = v_ok ? adj_q : '0;

    // candidate against the queried node's own row
    always_comb begin
        row_hit = 1'b0;
        for (int i = 0; i < DEGREE; i++) begin
            if (r_row[i] == cand) begin
                row_hit = 1'b1;
            end
        end
    end

    stnf_ram #(
        .WIDTH (ID_W),
        .DEPTH (ADJ_DEPTH),
        .AW    (ADJ_AW)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (in_nb),
        .i_raddr (adj_raddr),
        .o_rdata (adj_q)
    );

    stnf_ram #(
        .WIDTH (ID_W),
        .DEPTH (LIST_DEPTH),
        .AW    (LIST_AW)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata (r_cand),
        .i_raddr (list_raddr),
        .o_rdata (list_q)
    );

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_node   = r_node;
        n_row    = r_row;
        n_s      = r_s;
        n_s1     = r_s1;
        n_third  = r_third;
        n_v      = r_v;
        n_cand   = r_cand;
        n_k      = r_k;
        n_sc     = r_sc;
        n_tc     = r_tc;
        n_ovalid = r_ovalid;
        n_okind  = r_okind;
        n_onode  = r_onode;
        n_osc    = r_osc;
        n_otc    = r_otc;
        n_olast  = r_olast;
        list_we  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire && (in_action == ACT_QUERY)) begin
                    n_node  = in_node;
                    n_s     = '0;
                    n_sc    = '0;
                    n_tc    = '0;
                    n_state = ST_ROW_RD;
                end
            end

            // fetch the queried node's row, one slot per read
            ST_ROW_RD: begin
                n_state = ST_ROW_WT;
            end
            ST_ROW_WT: begin
                n_row[r_s[ROW_IW-1:0]] = node_ok ? adj_q : '0;
                if (r_s == SLOT_W'(DEGREE - 1)) begin
                    n_s1    = '0;
                    n_third = 1'b0;
                    n_state = ST_SRC;
                end else begin
                    n_s     = r_s + SLOT_W'(1);
                    n_state = ST_ROW_RD;
                end
            end

            // pick next source: row entries, then second-neighbor list
            ST_SRC: begin
                if (!r_third && (r_s1 == SC_W'(DEGREE))) begin
                    n_third = 1'b1;
                    n_s1    = '0;
                end else if (r_third && (r_s1 == r_sc)) begin
                    n_k     = '0;
                    n_state = ST_OUT_RD;
                end else begin
                    n_state = ST_SRC_WT;
                end
            end
            ST_SRC_WT: begin
                n_v     = r_third ? list_q : r_row[r_s1[ROW_IW-1:0]];
                n_s     = '0;
                n_state = ST_NB_RD;
            end

            // read one slot of the source
            ST_NB_RD: begin
                n_state = ST_NB_WT;
            end
            ST_NB_WT: begin
                n_cand = cand;
                if ((cand == r_node) || row_hit) begin
                    n_state = ST_NEXT;
                end else begin
                    n_k     = '0;
                    n_state = ST_SCAN;
                end
            end

            // duplicate search over the list, one entry per read
            ST_SCAN: begin
                if (r_k == scan_lim) begin
                    if (can_insert) begin
                        list_we = 1'b1;
                        if (r_third) begin
                            n_tc = r_tc + TC_W'(1);
                        end else begin
                            n_sc = r_sc + SC_W'(1);
                        end
                    end
                    n_state = ST_NEXT;
                end else begin
                    n_state = ST_SCAN_WT;
                end
            end
            ST_SCAN_WT: begin
                if (list_q == r_cand) begin
                    n_state = ST_NEXT;
                end else begin
                    n_k     = k_inc;
                    n_state = ST_SCAN;
                end
            end

            // advance to next slot or next source
            ST_NEXT: begin
                if (r_s == SLOT_W'(DEGREE - 1)) begin
                    n_s1    = r_s1 + SC_W'(1);
                    n_state = ST_SRC;
                end else begin
                    n_s     = r_s + SLOT_W'(1);
                    n_state = ST_NB_RD;
                end
            end

            // result beats
            ST_OUT_RD: begin
                if (total == '0) begin
                    n_okind  = KIND_NONE;
                    n_onode  = '0;
                    n_osc    = '0;
                    n_otc    = '0;
                    n_olast  = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = ST_OUT_HOLD;
                end else begin
                    n_state = ST_OUT_WT;
                end
            end
            ST_OUT_WT: begin
                n_okind  = (r_k < LIST_AW'(r_sc)) ? KIND_SECOND : KIND_THIRD;
                n_onode  = list_q;
                n_olast  = (k_inc == total);
                n_osc    = (k_inc == total) ? r_sc : '0;
                n_otc    = (k_inc == total) ? r_tc : '0;
                n_ovalid = 1'b1;
                n_state  = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (out_fire) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = k_inc;
                        n_state = ST_OUT_RD;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_sc     <= '0;
            r_tc     <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_sc     <= n_sc;
            r_tc     <= n_tc;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_row   <= n_row;
        r_s     <= n_s;
        r_s1    <= n_s1;
        r_third <= n_third;
        r_v     <= n_v;
        r_cand  <= n_cand;
        r_k     <= n_k;
        r_okind <= n_okind;
        r_onode <= n_onode;
        r_osc   <= n_osc;
        r_otc   <= n_otc;
        r_olast <= n_olast;
    end

    // ports
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - ID_W - SC_W - TC_W)'(0), r_otc, r_osc, r_onode};
    assign o_m_axis_tuser  = r_okind;
    assign o_m_axis_tlast  = r_olast;

endmodule

>>> sim/second_third_neighbor_finder_tb.sv
// Testbench for second_third_neighbor_finder: builds small graphs in the
// adjacency table, queries nodes and checks each result beat against a local
// predictor of the distance-two/three walk. Depends on stnf_pkg and the RTL.
`timescale 1ns / 1ps

module second_third_neighbor_finder_tb;
    import stnf_pkg::*;

    localparam int QUIET_LIMIT  = 30000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] found;
        logic [SC_W-1:0] sec_cnt;
        logic [TC_W-1:0] thr_cnt;
        logic            last;
    } t_neighbor_beat;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;   // node[9:0], slot[11:10], neighbor[21:12]
    logic                   i_s_axis_tuser = 1'b0; // action[0]
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;        // found_node[9:0], second_count[13:10],
                                                   // third_count[19:14]
    logic [1:0]             o_m_axis_tuser;        // kind[1:0]
    logic                   o_m_axis_tlast;

    // Local copy of the adjacency table and which slots hold a real id
    logic [ID_W-1:0] adj_mem [ADJ_DEPTH];
    bit              slot_written [ADJ_DEPTH];
    bit              row_gap;

    t_neighbor_beat  pending_beats [$];
    t_neighbor_beat  got_beat, want_beat;
    int              mismatch_count = 0;
    int              items_sent = 0;
    int              quiet_cycles = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;

    // Long receiver hold-off, requested by a test, counted by the receiver
    int              stall_len = 0;
    int              stall_req_seq = 0;
    int              stall_seen_seq = 0;
    int              stall_left = 0;

    second_third_neighbor_finder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // Predictor helpers: slot read that flags never-written entries
    function automatic logic [ID_W-1:0] adj_slot(input logic [ID_W-1:0] id, input int s);
        int idx;
        idx = int'(id) * DEGREE + s;
        if (!slot_written[idx])
            row_gap = 1'b1;
        return adj_mem[idx];
    endfunction

    function automatic bit in_root_row(input logic [ID_W-1:0] root,
                                       input logic [ID_W-1:0] cand);
        for (int s = 0; s < DEGREE; s++)
            if (adj_slot(root, s) == cand)
                return 1'b1;
        return 1'b0;
    endfunction

    // Walk from root: second neighbors, then third. Returns 0 if the walk
    // would touch an unwritten slot; pushes the result beats when commit is set.
    function automatic bit find_far_neighbors(input logic [ID_W-1:0] root, input bit commit);
        logic [ID_W-1:0] sec_ids [SEC_CAP];
        logic [ID_W-1:0] thr_ids [LIST_DEPTH];
        int              n_sec;
        int              n_thr;
        int              total;
        logic [ID_W-1:0] hop;
        logic [ID_W-1:0] cand;
        bit              seen;
        t_neighbor_beat  beat;
        n_sec   = 0;
        n_thr   = 0;
        row_gap = 1'b0;
        // second neighbors: through each slot of the root
        for (int s1 = 0; s1 < DEGREE; s1++) begin
            hop = adj_slot(root, s1);
            for (int s2 = 0; s2 < DEGREE; s2++) begin
                cand = adj_slot(hop, s2);
                if (cand == root || in_root_row(root, cand))
                    continue;
                seen = 1'b0;
                for (int k = 0; k < n_sec; k++)
                    if (sec_ids[k] == cand)
                        seen = 1'b1;
                if (seen)
                    continue;
                if (n_sec < SEC_CAP) begin
                    sec_ids[n_sec] = cand;
                    n_sec++;
                end
            end
        end
        // third neighbors: through each slot of each second neighbor
        for (int s1 = 0; s1 < n_sec; s1++) begin
            hop = sec_ids[s1];
            for (int s2 = 0; s2 < DEGREE; s2++) begin
                cand = adj_slot(hop, s2);
                if (cand == root || in_root_row(root, cand))
                    continue;
                seen = 1'b0;
                for (int k = 0; k < n_sec; k++)
                    if (sec_ids[k] == cand)
                        seen = 1'b1;
                for (int k = 0; k < n_thr; k++)
                    if (thr_ids[k] == cand)
                        seen = 1'b1;
                if (seen)
                    continue;
                if (n_sec + n_thr < LIST_DEPTH) begin
                    thr_ids[n_thr] = cand;
                    n_thr++;
                end
            end
        end
        if (row_gap)
            return 1'b0;
        if (!commit)
            return 1'b1;
        total = n_sec + n_thr;
        if (total == 0) begin
            beat = '{kind: KIND_NONE, found: '0, sec_cnt: '0, thr_cnt: '0, last: 1'b1};
            pending_beats.push_back(beat);
        end
        for (int k = 0; k < total; k++) begin
            beat.kind    = (k < n_sec) ? KIND_SECOND : KIND_THIRD;
            beat.found   = (k < n_sec) ? sec_ids[k] : thr_ids[k - n_sec];
            beat.last    = (k == total - 1);
            beat.sec_cnt = beat.last ? n_sec[SC_W-1:0] : '0;
            beat.thr_cnt = beat.last ? n_thr[TC_W-1:0] : '0;
            pending_beats.push_back(beat);
        end
        return 1'b1;
    endfunction

    // Drive one input beat and wait for it to be taken
    task automatic send_beat(input logic act, input logic [ID_W-1:0] nd,
                             input logic [SLOT_W-1:0] sl, input logic [ID_W-1:0] nb);
        // idle cycles drawn one at a time at the requested percentage
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, nb, sl, nd};
        i_s_axis_tuser  <= act;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic write_slot(input logic [ID_W-1:0] nd, input logic [SLOT_W-1:0] sl,
                              input logic [ID_W-1:0] nb);
        int idx;
        idx = int'(nd) * DEGREE + int'(sl);
        // slots at or above DEGREE are dropped by the block
        if (int'(sl) < DEGREE) begin
            adj_mem[idx]      = nb;
            slot_written[idx] = 1'b1;
            items_sent++;
        end
        send_beat(ACT_WRITE, nd, sl, nb);
    endtask

    // Query only when every slot the walk reads has been written
    task automatic query_node(input logic [ID_W-1:0] nd);
        if (find_far_neighbors(nd, 1'b1)) begin
            items_sent++;
            send_beat(ACT_QUERY, nd, SLOT_W'($urandom_range(0, 3)), ID_W'($urandom()));
        end
    endtask

    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random cluster: rows mostly point back into the cluster
    task automatic run_cluster_round();
        logic [ID_W-1:0] members [12];
        int              size;
        int              base;
        bit              spread;
        logic [ID_W-1:0] nb;
        logic [ID_W-1:0] pick;
        size   = $urandom_range(4, 12);
        base   = $urandom_range(0, NODES - 1);
        spread = $urandom_range(1);
        for (int m = 0; m < size; m++)
            members[m] = spread ? ID_W'($urandom_range(0, NODES - 1))
                                : ID_W'((base + $urandom_range(0, 15)) % NODES);
        for (int m = 0; m < size; m++) begin
            if ($urandom_range(9) == 0)
                write_slot(ID_W'($urandom()), 2'd3, ID_W'($urandom()));
            for (int s = 0; s < DEGREE; s++) begin
                nb = ($urandom_range(99) < 92) ? members[$urandom_range(0, size - 1)]
                                               : ID_W'($urandom_range(0, NODES - 1));
                write_slot(members[m], SLOT_W'(s), nb);
            end
        end
        repeat ($urandom_range(2, 5)) begin
            for (int t = 0; t < 4; t++) begin
                pick = members[$urandom_range(0, size - 1)];
                if (find_far_neighbors(pick, 1'b0)) begin
                    query_node(pick);
                    break;
                end
            end
        end
    endtask

    // Full ternary tree of distinct ids: root query yields the most results
    task automatic run_tree_round();
        bit              id_taken [NODES];
        logic [ID_W-1:0] tree_ids [40];
        logic [ID_W-1:0] id;
        for (int k = 0; k < 40; k++) begin
            do id = ID_W'($urandom_range(0, NODES - 1)); while (id_taken[id]);
            id_taken[id] = 1'b1;
            tree_ids[k]  = id;
        end
        // node k has children 3k+1 .. 3k+3; leaves keep unwritten rows
        for (int k = 0; k < 13; k++)
            for (int s = 0; s < DEGREE; s++)
                write_slot(tree_ids[k], SLOT_W'(s), tree_ids[3 * k + 1 + s]);
        query_node(tree_ids[0]);
        query_node(tree_ids[$urandom_range(1, 3)]);
    endtask

    // Scattered writes on any slot index, then a try at a query
    task automatic run_noise_round();
        logic [ID_W-1:0] nd;
        nd = '0;
        repeat ($urandom_range(4, 10)) begin
            nd = ID_W'($urandom());
            write_slot(nd, SLOT_W'($urandom_range(0, 3)), ID_W'($urandom()));
        end
        query_node(nd);
    endtask

    task automatic test_directed_graphs();
        logic [ID_W-1:0] quad [4];
        logic [ID_W-1:0] p0, p1, p2, p3;
        logic [SLOT_W-1:0] sl;
        quad = '{10'h000, 10'h3FF, 10'h155, 10'h2AA};
        p0 = 10'h200;
        p1 = 10'h3FE;
        p2 = 10'h001;
        p3 = 10'h2FF;
        // complete graph on four nodes: every walk closes back, nothing found
        for (int a = 0; a < 4; a++)
            for (int b = 0; b < 4; b++)
                if (b != a) begin
                    sl = (b > a) ? SLOT_W'(b - 1) : SLOT_W'(b);
                    write_slot(quad[a], sl, quad[b]);
                end
        // slot index equal to DEGREE on the row just below a quad node: dropped,
        // must not spill into the next row
        write_slot(10'h154, 2'd3, 10'h0F0);
        query_node(quad[2]);
        query_node(quad[1]);
        // short chain with repeated slots and a self loop: one of each kind
        write_slot(p0, 2'd0, p1);
        write_slot(p0, 2'd1, p1);
        write_slot(p0, 2'd2, p0);
        write_slot(p1, 2'd0, p0);
        write_slot(p1, 2'd1, p2);
        write_slot(p1, 2'd2, p2);
        write_slot(p2, 2'd0, p1);
        write_slot(p2, 2'd1, p3);
        write_slot(p2, 2'd2, p3);
        query_node(p0);
    endtask

    task automatic test_random_graphs(input int target);
        int pick;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 65)
                run_cluster_round();
            else if (pick < 80)
                run_tree_round();
            else
                run_noise_round();
        end
    endtask

    // Receiver holds off long enough that results back up and the input stalls
    task automatic test_backpressure();
        stall_len = 6000;
        stall_req_seq++;
        run_tree_round();
        run_cluster_round();
        wait_for_results();
    endtask

    // Receiver ready: random idling, or a requested hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_req_seq != stall_seen_seq) begin
            stall_seen_seq  <= stall_req_seq;
            stall_left      <= stall_len;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left      <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker: each taken beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_beat.kind    = o_m_axis_tuser;
            got_beat.found   = o_m_axis_tdata[ID_W-1:0];
            got_beat.sec_cnt = o_m_axis_tdata[ID_W +: SC_W];
            got_beat.thr_cnt = o_m_axis_tdata[ID_W + SC_W +: TC_W];
            got_beat.last    = o_m_axis_tlast;
            if (pending_beats.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: unexpected beat kind=%0d node=%0d sc=%0d tc=%0d last=%0d",
                             $realtime, got_beat.kind, got_beat.found, got_beat.sec_cnt,
                             got_beat.thr_cnt, got_beat.last);
                mismatch_count++;
            end else begin
                want_beat = pending_beats.pop_front();
                if (got_beat !== want_beat) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("%0t: mismatch expected kind=%0d node=%0d sc=%0d tc=%0d last=%0d",
                                 $realtime, want_beat.kind, want_beat.found,
                                 want_beat.sec_cnt, want_beat.thr_cnt, want_beat.last);
                        $display("%0t:          got kind=%0d node=%0d sc=%0d tc=%0d last=%0d",
                                 $realtime, got_beat.kind, got_beat.found,
                                 got_beat.sec_cnt, got_beat.thr_cnt, got_beat.last);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long without a beat on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("second_third_neighbor_finder test failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 23;
        recv_idle_pct = 71;
        test_directed_graphs();
        test_random_graphs(100);
        send_idle_pct = 71;
        recv_idle_pct = 23;
        test_random_graphs(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_graphs(300);
        test_backpressure();
        wait_for_results();
        if (mismatch_count == 0 && pending_beats.size() == 0)
            $display("second_third_neighbor_finder test passed");
        else
            $display("second_third_neighbor_finder test failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/stnf_pkg.sv
hw/rtl/stnf_ram.sv
hw/rtl/second_third_neighbor_finder.sv
sim/second_third_neighbor_finder_tb.sv
